/* sv/mhpq_pkg.sv */
`default_nettype none

package mhpq_pkg;

  localparam int CAPACITY     = 1024;
  localparam int KEY_WIDTH    = 32;
  localparam int LEVEL_WIDTH  = 6;
  localparam int HANDLE_WIDTH = 16;

  // Store index width and entry count width (the count must hold CAPACITY itself).
  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int STAT_W = 2;

  typedef struct packed {
    logic [KEY_WIDTH-1:0]    key;
    logic [LEVEL_WIDTH-1:0]  level;
    logic [HANDLE_WIDTH-1:0] handle;
  } entry_t;

  localparam logic KIND_INSERT  = 1'b0;
  localparam logic KIND_EXTRACT = 1'b1;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

endpackage

`default_nettype wire

/* sv/mhpq_if.sv */
`default_nettype none

interface mhpq_in_if;
  import mhpq_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    kind;
  logic [KEY_WIDTH-1:0]    key;
  logic [LEVEL_WIDTH-1:0]  level;
  logic [HANDLE_WIDTH-1:0] handle;

  modport source (output valid, output kind, output key, output level, output handle,
                  input ready);
  modport sink   (input valid, input kind, input key, input level, input handle,
                  output ready);
endinterface

interface mhpq_out_if;
  import mhpq_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [STAT_W-1:0]       status;
  logic [KEY_WIDTH-1:0]    out_key;
  logic [LEVEL_WIDTH-1:0]  out_level;
  logic [HANDLE_WIDTH-1:0] out_handle;
  logic [CNT_W-1:0]        occupancy;

  modport source (output valid, output status, output out_key, output out_level,
                  output out_handle, output occupancy, input ready);
  modport sink   (input valid, input status, input out_key, input out_level,
                  input out_handle, input occupancy, output ready);
endinterface

`default_nettype wire

/* sv/max_heap_priority_queue_top.sv */
// Binary max-heap priority queue held in one synchronous single-port-read store.
// An insert walks up from the new leaf, comparing the carried entry with each parent in turn.
// An extract reads the root, then the last entry, then walks down comparing child pairs.
// A dropped insert or an empty extract goes straight to the result. A new word is taken only
// when idle, after the last result has been placed in the output register.
// Reset (async, active low) empties the heap; store contents are left as they are.
`default_nettype none

module max_heap_priority_queue_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  mhpq_in_if.sink       in_i,
  mhpq_out_if.source    out_o
);
  import mhpq_pkg::*;

  localparam int IDX2_W = ADDR_W + 2;

  // Sequencer states.
  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_UP_CHK  = 4'd1;
  localparam logic [3:0] ST_UP_CMP  = 4'd2;
  localparam logic [3:0] ST_EX_ROOT = 4'd3;
  localparam logic [3:0] ST_EX_LAST = 4'd4;
  localparam logic [3:0] ST_DN_L    = 4'd5;
  localparam logic [3:0] ST_DN_R    = 4'd6;
  localparam logic [3:0] ST_DN_C    = 4'd7;
  localparam logic [3:0] ST_DONE    = 4'd8;

  // Heap store: one write and one registered read per cycle.
  entry_t              mem [CAPACITY];
  entry_t              rdata_q;
  logic [ADDR_W-1:0]   rd_addr;
  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  entry_t              wr_data;

  logic [3:0]          state_q, state_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [ADDR_W-1:0]   pos_q, pos_d;
  // The entry being moved through the tree. Sifting works with a hole: instead of
  // swapping at every level, displaced entries are written into the hole and the
  // carried entry is written once, where it comes to rest.
  entry_t              carry_q, carry_d;
  entry_t              left_q, left_d;
  entry_t              root_q, root_d;
  logic [STAT_W-1:0]   stat_q, stat_d;

  logic                ovalid_q, ovalid_d;
  logic [STAT_W-1:0]   ostat_q, ostat_d;
  entry_t              oent_q, oent_d;
  logic [CNT_W-1:0]    oocc_q, oocc_d;

  logic                accept;
  logic                out_free;
  logic [ADDR_W-1:0]   pos_m1;
  logic [ADDR_W-1:0]   parent;
  logic [IDX2_W-1:0]   lc;
  logic [IDX2_W-1:0]   rc;
  logic [IDX2_W-1:0]   cnt_ext;
  logic                lc_ok;
  logic                rc_ok;
  logic                pick_l;
  logic [KEY_WIDTH-1:0] best_key;
  logic                pick_r;
  entry_t              in_ent;

  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign out_free   = !ovalid_q || out_o.ready;

  assign in_ent.key    = in_i.key;
  assign in_ent.level  = in_i.level;
  assign in_ent.handle = in_i.handle;

  // Tree arithmetic: parent is (pos-1)/2, children are 2*pos+1 and 2*pos+2.
  assign pos_m1  = pos_q - ADDR_W'(1);
  assign parent  = {1'b0, pos_m1[ADDR_W-1:1]};
  assign lc      = {1'b0, pos_q, 1'b1};
  assign rc      = lc + IDX2_W'(1);
  assign cnt_ext = IDX2_W'(count_q);
  assign lc_ok   = lc < cnt_ext;
  assign rc_ok   = rc < cnt_ext;

  // Child selection: left first, a child wins only when strictly greater.
  assign pick_l   = carry_q.key < left_q.key;
  assign best_key = pick_l ? left_q.key : carry_q.key;
  assign pick_r   = rc_ok && (best_key < rdata_q.key);

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    pos_d    = pos_q;
    carry_d  = carry_q;
    left_d   = left_q;
    root_d   = root_q;
    stat_d   = stat_q;
    rd_addr  = pos_q;
    wr_en    = 1'b0;
    wr_addr  = pos_q;
    wr_data  = carry_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          root_d = '0;
          stat_d = STAT_OK;
          if (in_i.kind == KIND_INSERT) begin
            if (count_q == CNT_W'(CAPACITY)) begin
              stat_d  = STAT_FULL;
              state_d = ST_DONE;
            end else begin
              carry_d = in_ent;
              pos_d   = count_q[ADDR_W-1:0];
              count_d = count_q + CNT_W'(1);
              state_d = ST_UP_CHK;
            end
          end else begin
            if (count_q == '0) begin
              stat_d  = STAT_EMPTY;
              state_d = ST_DONE;
            end else begin
              rd_addr = '0;
              count_d = count_q - CNT_W'(1);
              state_d = ST_EX_ROOT;
            end
          end
        end
      end

      ST_UP_CHK: begin
        if (pos_q == '0) begin
          wr_en   = 1'b1;
          state_d = ST_DONE;
        end else begin
          rd_addr = parent;
          state_d = ST_UP_CMP;
        end
      end

      ST_UP_CMP: begin
        wr_en = 1'b1;
        if (carry_q.key > rdata_q.key) begin
          wr_data = rdata_q;
          pos_d   = parent;
          state_d = ST_UP_CHK;
        end else begin
          state_d = ST_DONE;
        end
      end

      ST_EX_ROOT: begin
        root_d  = rdata_q;
        rd_addr = count_q[ADDR_W-1:0];
        state_d = ST_EX_LAST;
      end

      ST_EX_LAST: begin
        carry_d = rdata_q;
        pos_d   = '0;
        state_d = (count_q == '0) ? ST_DONE : ST_DN_L;
      end

      ST_DN_L: begin
        if (lc_ok) begin
          rd_addr = lc[ADDR_W-1:0];
          state_d = ST_DN_R;
        end else begin
          wr_en   = 1'b1;
          state_d = ST_DONE;
        end
      end

      ST_DN_R: begin
        left_d  = rdata_q;
        rd_addr = rc[ADDR_W-1:0];
        state_d = ST_DN_C;
      end

      ST_DN_C: begin
        wr_en = 1'b1;
        if (pick_r) begin
          wr_data = rdata_q;
          pos_d   = rc[ADDR_W-1:0];
          state_d = ST_DN_L;
        end else if (pick_l) begin
          wr_data = left_q;
          pos_d   = lc[ADDR_W-1:0];
          state_d = ST_DN_L;
        end else begin
          state_d = ST_DONE;
        end
      end

      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output register: loaded when a finished word finds the slot free.
  always_comb begin
    ovalid_d = ovalid_q;
    ostat_d  = ostat_q;
    oent_d   = oent_q;
    oocc_d   = oocc_q;
    if (out_o.ready) begin
      ovalid_d = 1'b0;
    end
    if (state_q == ST_DONE && out_free) begin
      ovalid_d = 1'b1;
      ostat_d  = stat_q;
      oent_d   = root_q;
      oocc_d   = count_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q   <= pos_d;
    carry_q <= carry_d;
    left_q  <= left_d;
    root_q  <= root_d;
    stat_q  <= stat_d;
    ostat_q <= ostat_d;
    oent_q  <= oent_d;
    oocc_q  <= oocc_d;
  end

  assign out_o.valid      = ovalid_q;
  assign out_o.status     = ostat_q;
  assign out_o.out_key    = oent_q.key;
  assign out_o.out_level  = oent_q.level;
  assign out_o.out_handle = oent_q.handle;
  assign out_o.occupancy  = oocc_q;

endmodule

`default_nettype wire

/* sv/mhpq_checker.sv */
`default_nettype none

module mhpq_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              out_valid_i,
  input  logic                              out_ready_i,
  input  logic [mhpq_pkg::STAT_W-1:0]       status_i,
  input  logic [mhpq_pkg::KEY_WIDTH-1:0]    out_key_i,
  input  logic [mhpq_pkg::LEVEL_WIDTH-1:0]  out_level_i,
  input  logic [mhpq_pkg::HANDLE_WIDTH-1:0] out_handle_i,
  input  logic [mhpq_pkg::CNT_W-1:0]        occupancy_i
);
  import mhpq_pkg::*;

  // A dropped insert can only happen with the heap at capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == STAT_FULL |-> occupancy_i == CNT_W'(CAPACITY))
    else $error("full status with heap not at capacity");

  // An empty extract leaves the heap empty and returns a zero entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == STAT_EMPTY |->
      occupancy_i == '0 && out_key_i == '0 && out_level_i == '0 && out_handle_i == '0)
    else $error("empty status with nonzero word");

  // Occupancy never exceeds capacity, and no undefined status code appears.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> occupancy_i <= CNT_W'(CAPACITY) &&
      (status_i == STAT_OK || status_i == STAT_FULL || status_i == STAT_EMPTY))
    else $error("occupancy or status out of range");

  // A stalled result word holds its status, key and occupancy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i) &&
      $stable(out_key_i) && $stable(occupancy_i))
    else $error("stalled result word changed");

endmodule

bind max_heap_priority_queue_top mhpq_checker u_mhpq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .status_i     (out_o.status),
  .out_key_i    (out_o.out_key),
  .out_level_i  (out_o.out_level),
  .out_handle_i (out_o.out_handle),
  .occupancy_i  (out_o.occupancy)
);

`default_nettype wire
